// ----- rtl/bqdf2_pkg.sv -----
// Shared types and constants of the direct form II biquad section.
// Formats, coefficient set, controller commands and datapath status.
// No dependencies.
package bqdf2_pkg;

	// Data formats: samples Q1.23, coefficients Q4.20, state Q9.23
	localparam int SAMPLE_WIDTH = 24;
	localparam int COEF_WIDTH   = 24;
	localparam int STATE_WIDTH  = 32;
	localparam int LOAD_WIDTH   = 32;
	localparam int COEF_FRAC    = COEF_WIDTH - 4;

	// Product of one coefficient and one state value, and the accumulator
	localparam int PROD_WIDTH = COEF_WIDTH + STATE_WIDTH;
	localparam int ACC_WIDTH  = PROD_WIDTH + 2;

	// Configuration port
	localparam int NUM_REGS   = 5;
	localparam int ADDR_WIDTH = 5;
	localparam int DATA_WIDTH = 32;

	// Saturation limits, expressed at accumulator width
	localparam logic signed [ACC_WIDTH-1:0] W_MAX =
		ACC_WIDTH'({1'b0, {(STATE_WIDTH-1){1'b1}}});
	localparam logic signed [ACC_WIDTH-1:0] W_MIN = ~W_MAX;
	localparam logic signed [ACC_WIDTH-1:0] Y_MAX =
		ACC_WIDTH'({1'b0, {(SAMPLE_WIDTH-1){1'b1}}});
	localparam logic signed [ACC_WIDTH-1:0] Y_MIN = ~Y_MAX;

	// Item codes on the func field
	localparam logic FUNC_FILTER = 1'b0;
	localparam logic FUNC_LOAD   = 1'b1;

	typedef struct packed {
		logic [COEF_WIDTH-1:0] fb1;
		logic [COEF_WIDTH-1:0] fb2;
		logic [COEF_WIDTH-1:0] ff0;
		logic [COEF_WIDTH-1:0] ff1;
		logic [COEF_WIDTH-1:0] ff2;
	} coef_t;

	// Operand pair fed to the shared multiplier
	typedef enum logic [2:0] {
		MS_AA,
		MS_A_W1,
		MS_B_W2,
		MS_F0_W,
		MS_F1_W1,
		MS_F2_W2
	} mul_sel_t;

	// Accumulator operation
	typedef enum logic [1:0] {
		ACC_HOLD,
		ACC_LOAD_X,
		ACC_ADD,
		ACC_SET
	} acc_op_t;

	typedef struct packed {
		logic     load_delay;
		mul_sel_t mul_sel;
		acc_op_t  acc_op;
		logic     chk_stable;
		logic     round_w;
		logic     finish;
	} cmd_t;

	typedef struct packed {
		logic out_busy;
	} sts_t;

endpackage

// ----- rtl/bqdf2_if.sv -----
// Valid/ready channel interfaces for input items and result beats.
// Depends on bqdf2_pkg for field widths.
interface bqdf2_in_if;
	logic                                       valid;
	logic                                       ready;
	logic                                       func;
	logic signed [bqdf2_pkg::SAMPLE_WIDTH-1:0] sample_in;
	logic signed [bqdf2_pkg::LOAD_WIDTH-1:0]   load_last;
	logic signed [bqdf2_pkg::LOAD_WIDTH-1:0]   load_prev;

	modport source (output valid, func, sample_in, load_last, load_prev, input ready);
	modport sink (input valid, func, sample_in, load_last, load_prev, output ready);
endinterface

interface bqdf2_out_if;
	logic                                       valid;
	logic                                       ready;
	logic signed [bqdf2_pkg::SAMPLE_WIDTH-1:0] sample_out;

	modport source (output valid, sample_out, input ready);
	modport sink (input valid, sample_out, output ready);
endinterface

// ----- rtl/biquad_filter_direct_form_two.sv -----
// Direct form II biquad section, fixed point, with APB coefficient port.
// A filter item runs the feedback products, a w round step, the feedforward
// products and a y round step before its result beat comes out, longer only
// while the previous beat stalls; no new item is taken meanwhile, as one shared
// 24x32 multiplier does five products and the stability square. Loads set delays.
// Reset (arst_n, async, active low) clears coefficients and both delays.
module biquad_filter_direct_form_two (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [bqdf2_pkg::ADDR_WIDTH-1:0] paddr,
	input  logic [bqdf2_pkg::DATA_WIDTH-1:0] pwdata,
	output logic [bqdf2_pkg::DATA_WIDTH-1:0] prdata,
	output logic                             pready,
	bqdf2_in_if.sink                         din,
	bqdf2_out_if.source                      dout
);

	bqdf2_pkg::coef_t coef;
	bqdf2_pkg::cmd_t  cmd;
	bqdf2_pkg::sts_t  sts;

	bqdf2_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.coef    (coef)
	);

	bqdf2_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (din.valid),
		.in_func  (din.func),
		.in_ready (din.ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	bqdf2_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.coef       (coef),
		.sample_in  (din.sample_in),
		.load_last  (din.load_last),
		.load_prev  (din.load_prev),
		.sample_out (dout.sample_out),
		.out_valid  (dout.valid),
		.out_ready  (dout.ready)
	);

	// A load item never produces a result beat
	assert property (@(posedge clk) disable iff (!arst_n)
		(din.valid && din.ready && din.func == bqdf2_pkg::FUNC_LOAD) |=> !$rose(dout.valid))
		else $error("result beat raised after a load item");

	// A filter item keeps the input closed while it is being worked
	assert property (@(posedge clk) disable iff (!arst_n)
		(din.valid && din.ready && din.func == bqdf2_pkg::FUNC_FILTER) |=> !din.ready)
		else $error("input reopened right after a filter item");

	// A new result beat only comes out of a busy cycle
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(dout.valid) |-> $past(!din.ready))
		else $error("result beat raised while idle");

	// A waiting result beat is never overwritten
	assert property (@(posedge clk) disable iff (!arst_n)
		(dout.valid && !dout.ready) |=> (dout.valid && $stable(dout.sample_out)))
		else $error("stalled result beat changed");

endmodule

// ----- rtl/bqdf2_regs.sv -----
// Coefficient register file behind the APB-style configuration port.
// Depends on bqdf2_pkg.
module bqdf2_regs (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [bqdf2_pkg::ADDR_WIDTH-1:0] paddr,
	input  logic [bqdf2_pkg::DATA_WIDTH-1:0] pwdata,
	output logic [bqdf2_pkg::DATA_WIDTH-1:0] prdata,
	output logic                             pready,
	output bqdf2_pkg::coef_t                 coef
);

	localparam logic [2:0] REG_FB1 = 3'd0;
	localparam logic [2:0] REG_FB2 = 3'd1;
	localparam logic [2:0] REG_FF0 = 3'd2;
	localparam logic [2:0] REG_FF1 = 3'd3;
	localparam logic [2:0] REG_FF2 = 3'd4;

	bqdf2_pkg::coef_t coef_q;
	logic [2:0]       reg_idx;
	logic             wr_en;
	logic [bqdf2_pkg::COEF_WIDTH-1:0] rd_val;

	assign pready  = 1'b1;
	assign reg_idx = paddr[bqdf2_pkg::ADDR_WIDTH-1:2];
	assign wr_en   = psel && penable && pwrite && pready;

	// Write the addressed coefficient, drop writes beyond the last register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_q <= '0;
		end else if (wr_en) begin
			case (reg_idx)
				REG_FB1: coef_q.fb1 <= pwdata[bqdf2_pkg::COEF_WIDTH-1:0];
				REG_FB2: coef_q.fb2 <= pwdata[bqdf2_pkg::COEF_WIDTH-1:0];
				REG_FF0: coef_q.ff0 <= pwdata[bqdf2_pkg::COEF_WIDTH-1:0];
				REG_FF1: coef_q.ff1 <= pwdata[bqdf2_pkg::COEF_WIDTH-1:0];
				REG_FF2: coef_q.ff2 <= pwdata[bqdf2_pkg::COEF_WIDTH-1:0];
				default: ;
			endcase
		end
	end

	// Read back the addressed coefficient
	always_comb begin
		case (reg_idx)
			REG_FB1: rd_val = coef_q.fb1;
			REG_FB2: rd_val = coef_q.fb2;
			REG_FF0: rd_val = coef_q.ff0;
			REG_FF1: rd_val = coef_q.ff1;
			REG_FF2: rd_val = coef_q.ff2;
			default: rd_val = '0;
		endcase
	end

	assign prdata = bqdf2_pkg::DATA_WIDTH'(rd_val);
	assign coef   = coef_q;

endmodule

// ----- rtl/bqdf2_ctrl.sv -----
// Sequencing state machine of the biquad: one shared multiplier, five
// products and two round/saturate steps per sample. Depends on bqdf2_pkg.
module bqdf2_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	input  logic            in_func,
	output logic            in_ready,
	input  bqdf2_pkg::sts_t sts,
	output bqdf2_pkg::cmd_t cmd
);

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_FB1,
		ST_FB2,
		ST_FIN_W,
		ST_RND_W,
		ST_FF0,
		ST_FF1,
		ST_FF2,
		ST_FIN_Y,
		ST_RND_Y
	} state_t;

	state_t state_q;
	logic   accept;

	assign in_ready = (state_q == ST_IDLE);
	assign accept   = in_valid && in_ready;

	// Advance through the product schedule; hold the last step while the
	// previous result beat is still waiting
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept && (in_func == bqdf2_pkg::FUNC_FILTER)) state_q <= ST_FB1;
				end
				ST_FB1:   state_q <= ST_FB2;
				ST_FB2:   state_q <= ST_FIN_W;
				ST_FIN_W: state_q <= ST_RND_W;
				ST_RND_W: state_q <= ST_FF0;
				ST_FF0:   state_q <= ST_FF1;
				ST_FF1:   state_q <= ST_FF2;
				ST_FF2:   state_q <= ST_FIN_Y;
				ST_FIN_Y: state_q <= ST_RND_Y;
				ST_RND_Y: begin
					if (!sts.out_busy) state_q <= ST_IDLE;
				end
				default:  state_q <= ST_IDLE;
			endcase
		end
	end

	// Decode commands for the datapath
	always_comb begin
		cmd            = '0;
		cmd.mul_sel    = bqdf2_pkg::MS_AA;
		cmd.acc_op     = bqdf2_pkg::ACC_HOLD;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (in_func == bqdf2_pkg::FUNC_LOAD) cmd.load_delay = 1'b1;
					else cmd.acc_op = bqdf2_pkg::ACC_LOAD_X;
				end
			end
			ST_FB1: begin
				cmd.mul_sel    = bqdf2_pkg::MS_A_W1;
				cmd.chk_stable = 1'b1;
			end
			ST_FB2: begin
				cmd.mul_sel = bqdf2_pkg::MS_B_W2;
				cmd.acc_op  = bqdf2_pkg::ACC_ADD;
			end
			ST_FIN_W: cmd.acc_op = bqdf2_pkg::ACC_ADD;
			ST_RND_W: cmd.round_w = 1'b1;
			ST_FF0:   cmd.mul_sel = bqdf2_pkg::MS_F0_W;
			ST_FF1: begin
				cmd.mul_sel = bqdf2_pkg::MS_F1_W1;
				cmd.acc_op  = bqdf2_pkg::ACC_SET;
			end
			ST_FF2: begin
				cmd.mul_sel = bqdf2_pkg::MS_F2_W2;
				cmd.acc_op  = bqdf2_pkg::ACC_ADD;
			end
			ST_FIN_Y: cmd.acc_op = bqdf2_pkg::ACC_ADD;
			ST_RND_Y: cmd.finish = !sts.out_busy;
			default: ;
		endcase
	end

endmodule

// ----- rtl/bqdf2_dp.sv -----
// Datapath of the biquad: shared multiplier, accumulator, stability check,
// rounding/saturation, delay line and output register. Depends on bqdf2_pkg.
module bqdf2_dp (
	input  logic                                      clk,
	input  logic                                      arst_n,
	input  bqdf2_pkg::cmd_t                           cmd,
	output bqdf2_pkg::sts_t                           sts,
	input  bqdf2_pkg::coef_t                          coef,
	input  logic signed [bqdf2_pkg::SAMPLE_WIDTH-1:0] sample_in,
	input  logic signed [bqdf2_pkg::LOAD_WIDTH-1:0]   load_last,
	input  logic signed [bqdf2_pkg::LOAD_WIDTH-1:0]   load_prev,
	output logic signed [bqdf2_pkg::SAMPLE_WIDTH-1:0] sample_out,
	output logic                                      out_valid,
	input  logic                                      out_ready
);

	localparam int CW   = bqdf2_pkg::COEF_WIDTH;
	localparam int SW   = bqdf2_pkg::STATE_WIDTH;
	localparam int AW   = bqdf2_pkg::ACC_WIDTH;
	localparam int PW   = bqdf2_pkg::PROD_WIDTH;
	localparam int FR   = bqdf2_pkg::COEF_FRAC;
	localparam int XW   = bqdf2_pkg::SAMPLE_WIDTH;
	localparam int DW   = PW + 1;
	localparam int TW   = CW + 2;

	logic signed [CW-1:0] op_a;
	logic signed [SW-1:0] op_b;
	logic signed [PW-1:0] prod_q;
	logic signed [AW-1:0] acc_q;
	logic signed [AW-1:0] addend;
	logic signed [AW-1:0] rnd_sum;
	logic signed [AW-1:0] rnd_val;
	logic signed [SW-1:0] w_q;
	logic signed [SW-1:0] w1_q;
	logic signed [SW-1:0] w2_q;
	logic signed [SW-1:0] w_sat;
	logic signed [XW-1:0] y_sat;
	logic signed [XW-1:0] sample_out_q;
	logic                 out_valid_q;
	logic                 stable_q;
	logic                 stable;
	logic signed [DW-1:0] disc;
	logic signed [TW-1:0] a_x;
	logic signed [TW-1:0] b_x;
	logic signed [TW-1:0] one_x;
	logic signed [TW-1:0] sum_m;
	logic signed [TW-1:0] sum_p;

	// Select the multiplier operands
	always_comb begin
		case (cmd.mul_sel)
			bqdf2_pkg::MS_AA: begin
				op_a = $signed(coef.fb1);
				op_b = $signed({{(SW-CW){coef.fb1[CW-1]}}, coef.fb1});
			end
			bqdf2_pkg::MS_A_W1: begin
				op_a = $signed(coef.fb1);
				op_b = w1_q;
			end
			bqdf2_pkg::MS_B_W2: begin
				op_a = $signed(coef.fb2);
				op_b = w2_q;
			end
			bqdf2_pkg::MS_F0_W: begin
				op_a = $signed(coef.ff0);
				op_b = w_q;
			end
			bqdf2_pkg::MS_F1_W1: begin
				op_a = $signed(coef.ff1);
				op_b = w1_q;
			end
			bqdf2_pkg::MS_F2_W2: begin
				op_a = $signed(coef.ff2);
				op_b = w2_q;
			end
			default: begin
				op_a = '0;
				op_b = '0;
			end
		endcase
	end

	// Stability test on the feedback pair; the product register holds fb1*fb1
	assign disc  = $signed({prod_q[PW-1], prod_q}) +
		$signed({{(DW-CW-FR-2){coef.fb2[CW-1]}}, coef.fb2, {(FR+2){1'b0}}});
	assign a_x   = $signed({{2{coef.fb1[CW-1]}}, coef.fb1});
	assign b_x   = $signed({{2{coef.fb2[CW-1]}}, coef.fb2});
	assign one_x = $signed(TW'(1) << FR);
	assign sum_m = one_x - a_x - b_x;
	assign sum_p = one_x + a_x - b_x;

	always_comb begin
		if (disc[DW-1]) begin
			// complex roots: pole radius bound
			stable = (b_x >= -one_x);
		end else begin
			// real roots: both roots inside the unit interval
			stable = (a_x <= (one_x <<< 1)) && (a_x >= -(one_x <<< 1)) &&
				!sum_m[TW-1] && !sum_p[TW-1];
		end
	end

	// Zero every product when the coefficient set is unstable
	assign addend = stable_q ? AW'(prod_q) : '0;

	// Round to nearest, ties up, then saturate to state and sample ranges
	assign rnd_sum = acc_q + $signed(AW'(1) << (FR - 1));
	assign rnd_val = rnd_sum >>> FR;

	always_comb begin
		if (rnd_val > bqdf2_pkg::W_MAX) w_sat = bqdf2_pkg::W_MAX[SW-1:0];
		else if (rnd_val < bqdf2_pkg::W_MIN) w_sat = bqdf2_pkg::W_MIN[SW-1:0];
		else w_sat = rnd_val[SW-1:0];

		if (rnd_val > bqdf2_pkg::Y_MAX) y_sat = bqdf2_pkg::Y_MAX[XW-1:0];
		else if (rnd_val < bqdf2_pkg::Y_MIN) y_sat = bqdf2_pkg::Y_MIN[XW-1:0];
		else y_sat = rnd_val[XW-1:0];
	end

	// Multiply, accumulate and hold the new intermediate value
	always_ff @(posedge clk) begin
		prod_q <= op_a * op_b;
		case (cmd.acc_op)
			bqdf2_pkg::ACC_LOAD_X: acc_q <= $signed({{(AW-XW-FR){sample_in[XW-1]}},
				sample_in, {FR{1'b0}}});
			bqdf2_pkg::ACC_ADD:    acc_q <= acc_q + addend;
			bqdf2_pkg::ACC_SET:    acc_q <= addend;
			default: ;
		endcase
		if (cmd.round_w) w_q <= w_sat;
		if (cmd.finish) sample_out_q <= y_sat;
	end

	// Delay line, stability flag and output beat flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			w1_q        <= '0;
			w2_q        <= '0;
			stable_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.load_delay) begin
				w1_q <= load_last;
				w2_q <= load_prev;
			end else if (cmd.finish) begin
				w1_q <= w_q;
				w2_q <= w1_q;
			end
			if (cmd.chk_stable) stable_q <= stable;
			if (cmd.finish) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	assign sts.out_busy = out_valid_q && !out_ready;
	assign sample_out   = sample_out_q;
	assign out_valid    = out_valid_q;

endmodule
